// ===== design/polygon_scanline_fill_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the polygon scanline fill core
// Shared concurrent-assertion shorthands, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef POLYGON_SCANLINE_FILL_CORE_MACROS_SVH
`define POLYGON_SCANLINE_FILL_CORE_MACROS_SVH

// same-cycle implication
`define PSCF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pscf assertion failed");

// next-cycle implication
`define PSCF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pscf assertion failed");

`endif

// ===== design/pscf_pkg.sv =====
// ----------------------------------------------------------------------------
// Polygon scanline fill package
// Sizes, command codes, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package pscf_pkg;

  localparam int MAX_V = 32;
  localparam int AW    = $clog2(MAX_V);
  localparam int CW    = 14;
  localparam int DIV_STEPS = CW;

  // command codes on the input func field
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  localparam logic [1:0]  CFG_BUF_WIDTH  = 2'd0;
  localparam logic [1:0]  CFG_BUF_HEIGHT = 2'd1;
  localparam logic [12:0] BUF_DIM_MAX    = 13'd4096;
  localparam logic [12:0] BUF_DIM_RST    = 13'd256;

  typedef enum logic [4:0] {
    S_IDLE,
    S_OUT,
    S_BLD_PREV,
    S_BLD_CUR,
    S_BLD_DIV,
    S_BLD_WR,
    S_BLD_INS,
    S_BLD_END,
    S_ROW0,
    S_ROW,
    S_ADD,
    S_ADD_SHIFT,
    S_SPAN_L,
    S_SPAN_R,
    S_ADV,
    S_SORT_INIT,
    S_SORT,
    S_FIN
  } state_e;

endpackage

// ===== design/pscf_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel
// Vertex load / rasterize command beats, valid-ready handshake.
// ----------------------------------------------------------------------------
interface pscf_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic signed [13:0] vert_x;
  logic signed [13:0] vert_y;

  modport source (output valid, func, vert_x, vert_y, input ready);
  modport sink   (input valid, func, vert_x, vert_y, output ready);
endinterface

// ===== design/pscf_out_if.sv =====
// ----------------------------------------------------------------------------
// Output channel
// Span result beats, valid-ready handshake.
// ----------------------------------------------------------------------------
interface pscf_out_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] row;
  logic        [12:0] span_first;
  logic signed [12:0] span_last;
  logic               drawn;
  logic               last_span;
  logic               finished;
  logic               load_ack;

  modport source (output valid, row, span_first, span_last, drawn, last_span,
                  finished, load_ack, input ready);
  modport sink   (input valid, row, span_first, span_last, drawn, last_span,
                  finished, load_ack, output ready);
endinterface

// ===== design/polygon_scanline_fill_core.sv =====
// A load beat's ack is valid the cycle after acceptance; no new beat is taken until that ack is taken.
// A step beat on a built table moves the edges that start on its row into the active list,
// emits the spans between active edge pairs, advances the edges and drops exhausted ones,
// then re-sorts the survivors by x; output stalls hold it at each span beat.
// The first step also builds the table, with an iterative division for each shallow edge.
// Reset: async active low; buffer size 256x256, no vertices, no table built.
// ----------------------------------------------------------------------------
// Polygon scanline fill core
// Edge table build with an iterative divider, then one scan line per beat.
// ----------------------------------------------------------------------------
`include "polygon_scanline_fill_core_macros.svh"

module polygon_scanline_fill_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  pscf_in_if.sink     in_i,
  pscf_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);
  import pscf_pkg::*;

  // stores
  logic signed [13:0] vx_mem [MAX_V];
  logic signed [13:0] vy_mem [MAX_V];
  logic signed [13:0] ex_mem [MAX_V];
  logic signed [13:0] esr_mem [MAX_V];
  logic signed [14:0] estep_mem [MAX_V];
  logic               eneg_mem [MAX_V];
  logic signed [15:0] eerr_mem [MAX_V];
  logic        [14:0] einc_mem [MAX_V];
  logic        [13:0] edec_mem [MAX_V];
  logic        [14:0] erl_mem [MAX_V];
  logic [AW-1:0]      pend_mem [MAX_V];
  logic [AW-1:0]      act_mem [MAX_V];

  // control and datapath registers
  state_e state_q, state_d, ret_q, ret_d;
  logic built_q, built_d;
  logic [AW:0] vcnt_q, vcnt_d, total_q, total_d, head_q, head_d, nact_q, nact_d;
  logic [AW:0] i_q, i_d, n_q, n_d, k_q, k_d, w_q, w_d, lim_q, lim_d;
  logic [12:0] bw_q, bh_q;
  logic signed [13:0] row_q, row_d, px_q, px_d, py_q, py_d;
  logic signed [13:0] ebx_q, ebx_d, eby_q, eby_d, curx_q, curx_d, xl_q, xl_d;
  logic [13:0] edy_q, edy_d, edist_q, edist_d, divr_q, divr_d, divq_q, divq_d;
  logic [3:0]  divc_q, divc_d;
  logic        eneg_q, eneg_d, swp_q, swp_d;
  logic signed [15:0] eerr_q, eerr_d;
  logic [14:0] einc_q, einc_d;
  logic signed [14:0] estep_q, estep_d;
  logic [AW-1:0] cure_q, cure_d;
  logic [12:0] hf_q, hf_d;
  logic signed [12:0] hl_q, hl_d;
  logic        hd_q, hd_d;
  logic        ov_q, ov_d, olast_q, olast_d, ofin_q, ofin_d, oack_q, oack_d, odrawn_q, odrawn_d;
  logic signed [13:0] orow_q, orow_d;
  logic [12:0] ofirst_q, ofirst_d;
  logic signed [12:0] olast_x_q, olast_x_d;

  // store ports
  logic [AW-1:0] vtx_ra, pend_ra, act_ra, edge_ra, pend_rd, act_rd;
  logic          edge_from_pend;
  logic          vtx_we, bld_we, adv_we, pend_we, act_we;
  logic [AW-1:0] pend_wa, pend_wd, act_wa, act_wd;
  logic signed [13:0] ex_rd, esr_rd;

  assign pend_rd = pend_mem[pend_ra];
  assign act_rd  = act_mem[act_ra];
  assign edge_ra = edge_from_pend ? pend_rd : act_rd;
  assign ex_rd   = ex_mem[edge_ra];
  assign esr_rd  = esr_mem[edge_ra];

  // edge table build arithmetic
  logic signed [13:0] cx, cy, bx, by, tx, ty;
  logic signed [14:0] dy15, dx15;
  logic [13:0] dx_abs;
  logic [14:0] div_t;
  logic        div_ge;
  assign cx = vx_mem[vtx_ra];
  assign cy = vy_mem[vtx_ra];
  always_comb begin
    if (cy > py_q) begin
      bx = px_q; by = py_q; tx = cx; ty = cy;
    end else begin
      bx = cx; by = cy; tx = px_q; ty = py_q;
    end
  end
  assign dy15 = 15'({ty[13], ty} - {by[13], by});
  assign dx15 = 15'({tx[13], tx} - {bx[13], bx});
  assign dx_abs = dx15[14] ? 14'(-dx15) : dx15[13:0];
  assign div_t = {divr_q, divq_q[13]};
  assign div_ge = div_t >= {1'b0, edy_q};

  // edge advance arithmetic
  logic signed [15:0] adv_xs, adv_x2;
  logic signed [16:0] adv_es, adv_e2;
  logic [14:0] adv_rl;
  assign adv_rl = erl_mem[act_rd] - 15'd1;
  assign adv_xs = {{2{ex_rd[13]}}, ex_rd} + {estep_mem[act_rd][14], estep_mem[act_rd]};
  assign adv_es = {eerr_mem[act_rd][15], eerr_mem[act_rd]} + {2'b00, einc_mem[act_rd]};
  always_comb begin
    adv_x2 = adv_xs;
    adv_e2 = adv_es;
    if (adv_es > 17'sd0) begin
      adv_x2 = eneg_mem[act_rd] ? adv_xs - 16'sd1 : adv_xs + 16'sd1;
      adv_e2 = adv_es - {3'b000, edec_mem[act_rd]};
    end
  end

  // span clipping
  logic signed [15:0] sp_xl, sp_xr, sp_first, sp_wl, sp_min, sp_last, sp_row;
  logic [12:0]        sp_first_o;
  logic signed [12:0] sp_last_o;
  logic               sp_drawn;
  always_comb begin
    sp_xl    = {{2{xl_q[13]}}, xl_q};
    sp_xr    = {{2{ex_rd[13]}}, ex_rd};
    sp_row   = {{2{row_q[13]}}, row_q};
    sp_first = (sp_xl > 16'sd0) ? sp_xl : 16'sd0;
    sp_wl    = $signed({3'b000, bw_q});
    sp_min   = (sp_xr < sp_wl) ? sp_xr : sp_wl;
    sp_last  = sp_min - 16'sd1;
    sp_drawn = (sp_row >= 16'sd0) && (sp_row < $signed({3'b000, bh_q})) &&
               (sp_first <= sp_last);
    sp_first_o = sp_first[12:0];
    if (sp_last < -16'sd1) sp_last_o = -13'sd1;
    else if (sp_last > 16'sd4095) sp_last_o = 13'sd4095;
    else sp_last_o = sp_last[12:0];
  end

  // sequencer
  always_comb begin
    state_d = state_q; ret_d = ret_q; built_d = built_q;
    vcnt_d = vcnt_q; total_d = total_q; head_d = head_q; nact_d = nact_q;
    i_d = i_q; n_d = n_q; k_d = k_q; w_d = w_q; lim_d = lim_q;
    row_d = row_q; px_d = px_q; py_d = py_q; ebx_d = ebx_q; eby_d = eby_q;
    curx_d = curx_q; xl_d = xl_q; edy_d = edy_q; edist_d = edist_q;
    divr_d = divr_q; divq_d = divq_q; divc_d = divc_q; eneg_d = eneg_q;
    swp_d = swp_q; eerr_d = eerr_q; einc_d = einc_q; estep_d = estep_q;
    cure_d = cure_q; hf_d = hf_q; hl_d = hl_q; hd_d = hd_q;
    ov_d = ov_q; olast_d = olast_q; ofin_d = ofin_q; oack_d = oack_q;
    odrawn_d = odrawn_q; orow_d = orow_q; ofirst_d = ofirst_q; olast_x_d = olast_x_q;
    vtx_ra = i_q[AW-1:0]; pend_ra = head_q[AW-1:0]; act_ra = i_q[AW-1:0];
    edge_from_pend = 1'b0;
    vtx_we = 1'b0; bld_we = 1'b0; adv_we = 1'b0; pend_we = 1'b0; act_we = 1'b0;
    pend_wa = k_q[AW-1:0]; pend_wd = pend_rd; act_wa = k_q[AW-1:0]; act_wd = act_rd;
    in_i.ready = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          ov_d = 1'b1; olast_d = 1'b1; ofin_d = 1'b0; oack_d = 1'b0; odrawn_d = 1'b0;
          orow_d = '0; ofirst_d = '0; olast_x_d = '0;
          ret_d = S_IDLE;
          if (in_i.func == FUNC_LOAD) begin
            oack_d = 1'b1;
            state_d = S_OUT;
            if (!built_q && vcnt_q < (AW+1)'(MAX_V)) begin
              vtx_we = 1'b1;
              vcnt_d = vcnt_q + 1'b1;
            end
          end else if (built_q) begin
            ov_d = 1'b0;
            state_d = S_ROW;
          end else if (vcnt_q >= (AW+1)'(3)) begin
            ov_d = 1'b0;
            i_d = '0; n_d = '0;
            state_d = S_BLD_PREV;
          end else begin
            ofin_d = 1'b1; vcnt_d = '0;
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          ov_d = 1'b0;
          state_d = ret_q;
        end
      end
      S_BLD_PREV: begin
        vtx_ra = AW'(vcnt_q - 1'b1);
        px_d = cx; py_d = cy;
        state_d = S_BLD_CUR;
      end
      S_BLD_CUR: begin
        px_d = cx; py_d = cy;
        ebx_d = bx; eby_d = by; edy_d = dy15[13:0]; edist_d = dx_abs;
        eneg_d = (dx15 <= 15'sd0);
        eerr_d = dx15[14] ? 16'sd1 - $signed({2'b00, dy15[13:0]}) : 16'sd0;
        if (dy15 == 15'sd0) begin
          i_d = i_q + 1'b1;
          state_d = (i_q + 1'b1 == vcnt_q) ? S_BLD_END : S_BLD_CUR;
        end else if (dy15[13:0] >= dx_abs) begin
          einc_d = {1'b0, dx_abs}; estep_d = '0;
          state_d = S_BLD_WR;
        end else begin
          divr_d = '0; divq_d = dx_abs; divc_d = 4'(DIV_STEPS - 1);
          state_d = S_BLD_DIV;
        end
      end
      S_BLD_DIV: begin
        divr_d = div_ge ? 14'(div_t - {1'b0, edy_q}) : div_t[13:0];
        divq_d = {divq_q[12:0], div_ge};
        divc_d = divc_q - 1'b1;
        if (divc_q == '0) begin
          einc_d  = {1'b0, divr_d};
          estep_d = eneg_q ? -$signed({1'b0, divq_d}) : $signed({1'b0, divq_d});
          state_d = S_BLD_WR;
        end
      end
      S_BLD_WR: begin
        bld_we = 1'b1;
        k_d = n_q;
        state_d = S_BLD_INS;
      end
      S_BLD_INS: begin
        pend_ra = AW'(k_q - 1'b1);
        edge_from_pend = 1'b1;
        pend_we = 1'b1;
        if (k_q != '0 && (esr_rd > eby_q || (esr_rd == eby_q && ex_rd >= ebx_q))) begin
          pend_wd = pend_rd;
          k_d = k_q - 1'b1;
        end else begin
          pend_wd = n_q[AW-1:0];
          n_d = n_q + 1'b1;
          i_d = i_q + 1'b1;
          state_d = (i_q + 1'b1 == vcnt_q) ? S_BLD_END : S_BLD_CUR;
        end
      end
      S_BLD_END: begin
        if (n_q == '0) begin
          ov_d = 1'b1; olast_d = 1'b1; ofin_d = 1'b1; oack_d = 1'b0; odrawn_d = 1'b0;
          orow_d = '0; ofirst_d = '0; olast_x_d = '0;
          vcnt_d = '0; ret_d = S_IDLE;
          state_d = S_OUT;
        end else begin
          built_d = 1'b1; total_d = n_q; head_d = '0; nact_d = '0;
          state_d = S_ROW0;
        end
      end
      S_ROW0: begin
        pend_ra = '0;
        edge_from_pend = 1'b1;
        row_d = esr_rd;
        state_d = S_ROW;
      end
      S_ROW: begin
        lim_d = '0; hf_d = '0; hl_d = '0; hd_d = 1'b0;
        state_d = S_ADD;
      end
      S_ADD: begin
        edge_from_pend = 1'b1;
        if (head_q < total_q && esr_rd == row_q) begin
          cure_d = pend_rd; curx_d = ex_rd; k_d = nact_q;
          state_d = S_ADD_SHIFT;
        end else begin
          i_d = '0;
          state_d = S_SPAN_L;
        end
      end
      S_ADD_SHIFT: begin
        act_ra = AW'(k_q - 1'b1);
        act_we = 1'b1;
        if (k_q > lim_q && ex_rd >= curx_q) begin
          act_wd = act_rd;
          k_d = k_q - 1'b1;
        end else begin
          act_wd = cure_q;
          nact_d = nact_q + 1'b1;
          lim_d = k_q + 1'b1;
          head_d = head_q + 1'b1;
          state_d = S_ADD;
        end
      end
      S_SPAN_L: begin
        if (i_q + 1'b1 < nact_q) begin
          xl_d = ex_rd;
          state_d = S_SPAN_R;
        end else begin
          i_d = '0; w_d = '0;
          state_d = S_ADV;
        end
      end
      S_SPAN_R: begin
        act_ra = AW'(i_q + 1'b1);
        if ({1'b0, i_q} + (AW+2)'(3) < {1'b0, nact_q}) begin
          ov_d = 1'b1; olast_d = 1'b0; ofin_d = 1'b0; oack_d = 1'b0;
          orow_d = row_q; ofirst_d = sp_first_o; olast_x_d = sp_last_o; odrawn_d = sp_drawn;
          i_d = i_q + 2'd2;
          ret_d = S_SPAN_L;
          state_d = S_OUT;
        end else begin
          hf_d = sp_first_o; hl_d = sp_last_o; hd_d = sp_drawn;
          i_d = '0; w_d = '0;
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        if (i_q < nact_q) begin
          adv_we = 1'b1;
          i_d = i_q + 1'b1;
          if (adv_rl != '0) begin
            act_we = 1'b1; act_wa = w_q[AW-1:0]; act_wd = act_rd;
            w_d = w_q + 1'b1;
          end
        end else begin
          nact_d = w_q;
          state_d = S_SORT_INIT;
        end
      end
      S_SORT_INIT: begin
        act_ra = '0;
        if (nact_q < (AW+1)'(2)) begin
          state_d = S_FIN;
        end else begin
          cure_d = act_rd; curx_d = ex_rd; i_d = (AW+1)'(1); swp_d = 1'b0;
          state_d = S_SORT;
        end
      end
      S_SORT: begin
        act_we = 1'b1;
        if (i_q < nact_q) begin
          act_wa = AW'(i_q - 1'b1);
          i_d = i_q + 1'b1;
          if (curx_q > ex_rd) begin
            act_wd = act_rd; swp_d = 1'b1;
          end else begin
            act_wd = cure_q; cure_d = act_rd; curx_d = ex_rd;
          end
        end else begin
          act_wa = AW'(nact_q - 1'b1);
          act_wd = cure_q;
          state_d = swp_q ? S_SORT_INIT : S_FIN;
        end
      end
      S_FIN: begin
        row_d = row_q + 14'sd1;
        ov_d = 1'b1; olast_d = 1'b1; oack_d = 1'b0;
        orow_d = row_q; ofirst_d = hf_q; olast_x_d = hl_q; odrawn_d = hd_q;
        ofin_d = (head_q >= total_q) && (nact_q == '0);
        if (ofin_d) begin
          vcnt_d = '0; built_d = 1'b0;
        end
        ret_d = S_IDLE;
        state_d = S_OUT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ret_q <= S_IDLE; built_q <= 1'b0; ov_q <= 1'b0;
      vcnt_q <= '0; total_q <= '0; head_q <= '0; nact_q <= '0;
      bw_q <= BUF_DIM_RST; bh_q <= BUF_DIM_RST;
    end else begin
      state_q <= state_d; ret_q <= ret_d; built_q <= built_d; ov_q <= ov_d;
      vcnt_q <= vcnt_d; total_q <= total_d; head_q <= head_d; nact_q <= nact_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BUF_WIDTH:  bw_q <= (cfg_data_i == '0) ? 13'd1 :
                                  (cfg_data_i > BUF_DIM_MAX) ? BUF_DIM_MAX : cfg_data_i;
          CFG_BUF_HEIGHT: bh_q <= (cfg_data_i == '0) ? 13'd1 :
                                  (cfg_data_i > BUF_DIM_MAX) ? BUF_DIM_MAX : cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    i_q <= i_d; n_q <= n_d; k_q <= k_d; w_q <= w_d; lim_q <= lim_d;
    row_q <= row_d; px_q <= px_d; py_q <= py_d; ebx_q <= ebx_d; eby_q <= eby_d;
    curx_q <= curx_d; xl_q <= xl_d; edy_q <= edy_d; edist_q <= edist_d;
    divr_q <= divr_d; divq_q <= divq_d; divc_q <= divc_d; eneg_q <= eneg_d;
    swp_q <= swp_d; eerr_q <= eerr_d; einc_q <= einc_d; estep_q <= estep_d;
    cure_q <= cure_d; hf_q <= hf_d; hl_q <= hl_d; hd_q <= hd_d;
    olast_q <= olast_d; ofin_q <= ofin_d; oack_q <= oack_d; odrawn_q <= odrawn_d;
    orow_q <= orow_d; ofirst_q <= ofirst_d; olast_x_q <= olast_x_d;
  end

  // store writes
  always_ff @(posedge clk_i) begin
    if (vtx_we) begin
      vx_mem[vcnt_q[AW-1:0]] <= in_i.vert_x;
      vy_mem[vcnt_q[AW-1:0]] <= in_i.vert_y;
    end
    if (bld_we) begin
      ex_mem[n_q[AW-1:0]]    <= ebx_q;
      esr_mem[n_q[AW-1:0]]   <= eby_q;
      estep_mem[n_q[AW-1:0]] <= estep_q;
      eneg_mem[n_q[AW-1:0]]  <= eneg_q;
      eerr_mem[n_q[AW-1:0]]  <= eerr_q;
      einc_mem[n_q[AW-1:0]]  <= einc_q;
      edec_mem[n_q[AW-1:0]]  <= edy_q;
      erl_mem[n_q[AW-1:0]]   <= {1'b0, edy_q};
    end else if (adv_we) begin
      erl_mem[act_rd] <= adv_rl;
      ex_mem[act_rd]  <= adv_x2[13:0];
      eerr_mem[act_rd] <= adv_e2[15:0];
    end
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    if (act_we)  act_mem[act_wa] <= act_wd;
  end

  // result port
  assign out_o.valid      = ov_q;
  assign out_o.row        = orow_q;
  assign out_o.span_first = ofirst_q;
  assign out_o.span_last  = olast_x_q;
  assign out_o.drawn      = odrawn_q;
  assign out_o.last_span  = olast_q;
  assign out_o.finished   = ofin_q;
  assign out_o.load_ack   = oack_q;

  // checks
  `PSCF_ASSERT_IMP(a_rdy_no_out, in_i.ready, !out_o.valid)
  `PSCF_ASSERT_IMP(a_vcnt_max, 1'b1, vcnt_q <= (AW+1)'(MAX_V))
  `PSCF_ASSERT_IMP(a_fin_clear, out_o.valid && out_o.finished, !built_q && vcnt_q == '0)
  `PSCF_ASSERT_IMP(a_act_bound, built_q, nact_q <= total_q && head_q <= total_q)

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Polygon scanline fill core testbench
// Loads random and hand-picked polygons, steps them one scan line per beat
// and checks every span beat against a local scanline fill predictor, with
// random stalls on both channels and buffer size changes between phases.
// ----------------------------------------------------------------------------
module testbench;
  import pscf_pkg::*;

  typedef struct packed {
    logic signed [13:0] row;
    logic        [12:0] first;
    logic signed [12:0] last;
    logic               drawn;
    logic               last_span;
    logic               finished;
    logic               load_ack;
  } span_t;

  // Fill predictor: vertex store, edge table, active list and the span queue
  class fill_scoreboard;
    int buf_w = 256;
    int buf_h = 256;
    int vx[MAX_V], vy[MAX_V];
    int vcount;
    bit built;
    int pend_total, pend_head, n_active, cur_row;
    int ex[MAX_V], esr[MAX_V], estep[MAX_V], eneg[MAX_V];
    int eerr[MAX_V], einc[MAX_V], edec[MAX_V], eleft[MAX_V];
    int pend[MAX_V], act[MAX_V];
    span_t span_q[$];
    int errors;

    task report(string what);
      errors++;
      $display("ERROR: %s", what);
    endtask

    function void set_dim(logic [1:0] idx, int val);
      int v;
      v = val & 8191;
      if (v < 1) v = 1;
      if (v > 4096) v = 4096;
      if (idx == CFG_BUF_WIDTH) buf_w = v;
      else if (idx == CFG_BUF_HEIGHT) buf_h = v;
    endfunction

    function void push_span(int row, int first, int last, bit drawn, bit fin, bit ack);
      span_t s;
      if (first > 8191) first = 8191;
      if (last < -1) last = -1;
      if (last > 4095) last = 4095;
      s.row = 14'(row);
      s.first = 13'(first);
      s.last = 13'(last);
      s.drawn = drawn;
      s.last_span = 1'b0;
      s.finished = fin;
      s.load_ack = ack;
      span_q.push_back(s);
    endfunction

    // edge table, ordered by start row then x
    function int build_edges();
      int n, j, xb, yb, xe, ye, t, dx, dy, adx, p, q;
      n = 0;
      for (int i = 0; i < vcount; i++) begin
        j = (i != 0) ? i - 1 : vcount - 1;
        xb = vx[i]; yb = vy[i]; xe = vx[j]; ye = vy[j];
        if (yb > ye) begin
          t = xb; xb = xe; xe = t;
          t = yb; yb = ye; ye = t;
        end
        dy = ye - yb;
        if (dy == 0) continue;
        dx = xe - xb;
        eneg[n] = (dx <= 0);
        adx = (dx > 0) ? dx : -dx;
        ex[n] = xb;
        esr[n] = yb;
        eleft[n] = dy;
        edec[n] = dy;
        eerr[n] = (dx >= 0) ? 0 : 1 - dy;
        if (dy >= adx) begin
          einc[n] = adx;
          estep[n] = 0;
        end else begin
          einc[n] = adx % dy;
          estep[n] = eneg[n] ? -(adx / dy) : adx / dy;
        end
        p = 0;
        while (p < n && !(esr[pend[p]] > yb || (esr[pend[p]] == yb && ex[pend[p]] >= xb)))
          p++;
        for (q = n; q > p; q--) pend[q] = pend[q-1];
        pend[p] = n;
        n++;
      end
      return n;
    endfunction

    // accepted input beat: predict its span beats
    function void note(bit func, int x, int y);
      int n, yy, pos, e, k, xl, xr, first, last, w, t;
      bit swapped;
      if (func == FUNC_LOAD) begin
        if (!built && vcount < MAX_V) begin
          vx[vcount] = x;
          vy[vcount] = y;
          vcount++;
        end
        push_span(0, 0, 0, 0, 0, 1);
        span_q[span_q.size()-1].last_span = 1'b1;
        return;
      end
      if (!built) begin
        n = (vcount >= 3) ? build_edges() : 0;
        if (n == 0) begin
          push_span(0, 0, 0, 0, 1, 0);
          span_q[span_q.size()-1].last_span = 1'b1;
          vcount = 0;
          return;
        end
        built = 1;
        pend_total = n;
        pend_head = 0;
        n_active = 0;
        cur_row = esr[pend[0]];
      end
      yy = cur_row;
      // merge edges starting on this row
      pos = 0;
      while (pend_head < pend_total && esr[pend[pend_head]] == yy) begin
        e = pend[pend_head];
        while (pos < n_active && ex[act[pos]] < ex[e]) pos++;
        for (int q = n_active; q > pos; q--) act[q] = act[q-1];
        act[pos] = e;
        n_active++;
        pos++;
        pend_head++;
      end
      // spans between pairs
      k = 0;
      for (int i = 0; i + 1 < n_active; i += 2) begin
        xl = ex[act[i]];
        xr = ex[act[i+1]];
        first = (xl > 0) ? xl : 0;
        last = ((xr < buf_w) ? xr : buf_w) - 1;
        push_span(yy, first, last, yy >= 0 && yy < buf_h && first <= last, 0, 0);
        k++;
      end
      if (k == 0) push_span(yy, 0, 0, 0, 0, 0);
      // step edges, drop exhausted ones
      w = 0;
      for (int i = 0; i < n_active; i++) begin
        e = act[i];
        eleft[e]--;
        if (eleft[e] == 0) continue;
        ex[e] += estep[e];
        eerr[e] += einc[e];
        if (eerr[e] > 0) begin
          ex[e] += eneg[e] ? -1 : 1;
          eerr[e] -= edec[e];
        end
        act[w++] = e;
      end
      n_active = w;
      // bubble sort by x
      do begin
        swapped = 0;
        for (int i = 0; i + 1 < n_active; i++) begin
          if (ex[act[i]] > ex[act[i+1]]) begin
            t = act[i]; act[i] = act[i+1]; act[i+1] = t;
            swapped = 1;
          end
        end
      end while (swapped);
      cur_row = yy + 1;
      if (pend_head >= pend_total && n_active == 0) begin
        span_q[span_q.size()-1].finished = 1'b1;
        vcount = 0;
        built = 0;
      end
      span_q[span_q.size()-1].last_span = 1'b1;
    endfunction

    task check(span_t got);
      span_t want;
      if (span_q.size() == 0) begin
        report($sformatf("span beat with nothing expected: %p", got));
        return;
      end
      want = span_q.pop_front();
      if (got.row !== want.row)
        report($sformatf("row got %0d exp %0d", got.row, want.row));
      if (got.first !== want.first)
        report($sformatf("span_first got %0d exp %0d", got.first, want.first));
      if (got.last !== want.last)
        report($sformatf("span_last got %0d exp %0d", got.last, want.last));
      if (got.drawn !== want.drawn)
        report($sformatf("drawn got %b exp %b (row %0d)", got.drawn, want.drawn, want.row));
      if (got.last_span !== want.last_span)
        report($sformatf("last_span got %b exp %b", got.last_span, want.last_span));
      if (got.finished !== want.finished)
        report($sformatf("finished got %b exp %b", got.finished, want.finished));
      if (got.load_ack !== want.load_ack)
        report($sformatf("load_ack got %b exp %b", got.load_ack, want.load_ack));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [12:0] cfg_data_i;

  pscf_in_if  in_bus ();
  pscf_out_if out_bus ();

  polygon_scanline_fill_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  fill_scoreboard sb = new();
  bit idle_en = 1'b1;
  int beats_sent;
  int stall_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Generous overall limit
  initial begin
    #200_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Result side: check accepted beats, random stall bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      sb.check({out_bus.row, out_bus.span_first, out_bus.span_last, out_bus.drawn,
                out_bus.last_span, out_bus.finished, out_bus.load_ack});
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // one command beat, held until accepted
  task send(bit func, int x, int y);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.func <= func;
    in_bus.vert_x <= 14'(x);
    in_bus.vert_y <= 14'(y);
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note(func, x, y);
    beats_sent++;
  endtask

  // hold off until every expected span beat is back
  task drain();
    in_bus.valid <= 1'b0;
    while (sb.span_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task write_dim(logic [1:0] idx, int val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 13'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_dim(idx, val);
  endtask

  // step the loaded polygon to its end, sometimes poking a stray load in
  task fill_polygon();
    int guard;
    guard = 0;
    do begin
      send(FUNC_STEP, 0, 0);
      if (sb.built && $urandom_range(0, 19) == 0)
        send(FUNC_LOAD, $urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192);
      guard++;
    end while (sb.built && guard < 200);
  endtask

  task random_polygon();
    int n, bx, by, sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) n = $urandom_range(0, 2);
    else if (sel == 1) n = $urandom_range(9, MAX_V);
    else n = $urandom_range(3, 8);
    if ($urandom_range(0, 4) == 0) begin
      bx = $urandom_range(0, 16383 - 400) - 8192;
      by = $urandom_range(0, 16383 - 16) - 8192;
    end else begin
      bx = $urandom_range(0, 400) - 100;
      by = $urandom_range(0, sb.buf_h + 20) - 10;
    end
    for (int i = 0; i < n; i++)
      send(FUNC_LOAD, bx + $urandom_range(0, 300), by + $urandom_range(0, 12));
    fill_polygon();
  endtask

  // Stimulus
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_BUF_WIDTH;
    cfg_data_i = '0;
    in_bus.valid = 1'b0;
    in_bus.func = FUNC_LOAD;
    in_bus.vert_x = '0;
    in_bus.vert_y = '0;
    out_bus.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // degenerate cases: empty store, two vertices, only horizontal edges
    send(FUNC_STEP, 0, 0);
    send(FUNC_LOAD, 3, 4);
    send(FUNC_LOAD, 9, 8);
    send(FUNC_STEP, 0, 0);
    send(FUNC_LOAD, 0, 5);
    send(FUNC_LOAD, 10, 5);
    send(FUNC_LOAD, 3, 5);
    send(FUNC_STEP, 0, 0);
    // extreme x and y, off the buffer
    send(FUNC_LOAD, -8192, -8192);
    send(FUNC_LOAD, 8191, -8190);
    send(FUNC_LOAD, 0, -8188);
    send(FUNC_STEP, 0, 0);
    send(FUNC_LOAD, 7, 7);
    fill_polygon();
    send(FUNC_LOAD, 5, 8188);
    send(FUNC_LOAD, 300, 8191);
    send(FUNC_LOAD, -20, 8191);
    fill_polygon();
    // small triangle straddling the buffer edges
    send(FUNC_LOAD, -5, -2);
    send(FUNC_LOAD, 270, 3);
    send(FUNC_LOAD, 100, 6);
    fill_polygon();
    drain();

    // full store zigzag: 16 spans per row, then a load into a full store
    write_dim(CFG_BUF_WIDTH, 8191);
    write_dim(CFG_BUF_HEIGHT, 0);
    for (int i = 0; i < MAX_V; i++) send(FUNC_LOAD, i * 9 - 40, (i % 2) ? 0 : 6);
    send(FUNC_LOAD, 1, 1);
    fill_polygon();

    // random phases over several buffer sizes
    for (int ph = 0; beats_sent < 450; ph++) begin
      case (ph % 5)
        0: begin write_dim(CFG_BUF_WIDTH, 1); write_dim(CFG_BUF_HEIGHT, 4096); end
        1: begin write_dim(CFG_BUF_WIDTH, 0); write_dim(CFG_BUF_HEIGHT, 1); end
        2: begin write_dim(CFG_BUF_WIDTH, 4096); write_dim(CFG_BUF_HEIGHT, 8191); end
        default: begin
          write_dim(CFG_BUF_WIDTH, $urandom_range(1, 400));
          write_dim(CFG_BUF_HEIGHT, $urandom_range(1, 300));
        end
      endcase
      for (int p = 0; p < 6 && beats_sent < 450; p++) begin
        if (beats_sent > 380) idle_en = 1'b0;
        random_polygon();
      end
    end
    in_bus.valid <= 1'b0;

    while (sb.span_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
